>>> hw/rtl/hit_pkg.sv
// ----------------------------------------------------------------------------
// hit_pkg
// Shared types and constants for the held input tracker.
// ----------------------------------------------------------------------------
package hit_pkg;

  localparam int unsigned MAX_RELEASE = 64;
  localparam int unsigned NUM_KEYS    = 256;
  localparam int unsigned WORD_BITS   = 32;
  localparam int unsigned NUM_WORDS   = NUM_KEYS / WORD_BITS;
  localparam int unsigned KEY_W       = $clog2(NUM_KEYS);
  localparam int unsigned WIDX_W      = $clog2(NUM_WORDS);
  localparam int unsigned BIDX_W      = $clog2(WORD_BITS);
  localparam int unsigned CNT_W       = $clog2(MAX_RELEASE + 1);
  localparam int unsigned META_W      = 10;
  localparam int unsigned NUM_BTN     = 5;

  localparam logic [1:0] OP_KEY         = 2'd0;
  localparam logic [1:0] OP_MOUSE       = 2'd1;
  localparam logic [1:0] OP_RELEASE_ALL = 2'd2;

  localparam logic [1:0] KIND_STATUS  = 2'd0;
  localparam logic [1:0] KIND_KEY_REL = 2'd1;
  localparam logic [1:0] KIND_BTN_REL = 2'd2;
  localparam logic [1:0] KIND_NOTHING = 2'd3;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] key_code;
    logic [7:0] scan_byte;
    logic       key_up;
    logic       extended_key;
    logic       by_scan;
    logic [7:0] mouse_events;
    logic [1:0] x_select;
  } req_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] code;
    logic [7:0] release_scan;
    logic       release_extended;
    logic       virtual_mode;
    logic [7:0] held_count;
    logic [4:0] mouse_held;
    logic       changed;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic             set;
    logic             clr;
    logic [KEY_W-1:0] key;
  } map_ctrl_t;

  typedef struct packed {
    logic              key_held;
    logic              word_nz;
    logic [BIDX_W-1:0] first_idx;
    logic              any_held;
    logic              others_held;
  } map_stat_t;

endpackage

>>> hw/rtl/held_input_tracker_core.sv
// ----------------------------------------------------------------------------
// held_input_tracker_core
// Tracks held keys and mouse buttons; releases everything on request.
// ----------------------------------------------------------------------------
// Input channel carries one request (key event, mouse event or release-all);
// output channel carries result records from a single output register.
// Key and mouse events: the status result is valid in the cycle after the
// request is taken; a new request can be taken in the cycle that result
// goes, so events run at one per cycle with a receiver that never stalls.
// Release-all: walks the held-key bitmap one 32-bit word at a time, passing
// empty words (at most seven); each released key takes a scan step (bit
// cleared, metadata read through the single memory read port) and then an
// emit step; then each held mouse button gives one result, at most 64
// results. With nothing held, one result follows in the next cycle.
// Reset clears the bitmap, count and button mask; key metadata is not
// cleared and is only read for keys pressed since reset.
// A stalled result holds in the output register and no further result is
// emitted until it is taken; no new request is taken meanwhile.
// ----------------------------------------------------------------------------
module held_input_tracker_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  hit_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output hit_pkg::rsp_t out_rsp_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_EMIT,
    S_MOUSE
  } state_e;

  state_e                        state_q, state_d;
  logic [hit_pkg::WIDX_W-1:0]    w_q, w_d;
  logic [hit_pkg::CNT_W-1:0]     n_q, n_d;
  logic [hit_pkg::KEY_W-1:0]     key_q, key_d;
  logic                          last_q, last_d;
  logic [7:0]                    count_q, count_d;
  logic [hit_pkg::NUM_BTN-1:0]   mouse_q, mouse_d;
  hit_pkg::rsp_t                 out_q, out_d;
  logic                          out_valid_q, out_valid_d;

  hit_pkg::map_ctrl_t            map_ctrl;
  hit_pkg::map_stat_t            map_stat;
  logic                          ram_we;
  logic [hit_pkg::META_W-1:0]    ram_wdata;
  logic                          ram_re;
  logic [hit_pkg::KEY_W-1:0]     scan_key;
  logic [hit_pkg::META_W-1:0]    ram_rdata;

  logic                          slot_free;
  logic                          accept;
  logic                          at_limit;
  logic                          mchg;
  logic [hit_pkg::NUM_BTN-1:0]   mtmp;
  logic [hit_pkg::NUM_BTN-1:0]   mnext;
  logic [2:0]                    bsel;
  logic                          xdown;

  assign slot_free = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && slot_free);
  assign accept    = in_valid_i && !in_stall_o;
  assign scan_key  = {w_q, map_stat.first_idx};
  assign at_limit  = (n_q == hit_pkg::CNT_W'(hit_pkg::MAX_RELEASE - 1));

  // mouse event update: buttons 0-2 apply down before up; for the x buttons down wins
  always_comb begin
    mtmp = mouse_q;
    mchg = 1'b0;
    for (int b = 0; b < 3; b++) begin
      if (in_req_i.mouse_events[2*b] && !mtmp[b]) begin
        mtmp[b] = 1'b1;
        mchg    = 1'b1;
      end
      if (in_req_i.mouse_events[2*b+1] && mtmp[b]) begin
        mtmp[b] = 1'b0;
        mchg    = 1'b1;
      end
    end
    xdown = in_req_i.mouse_events[6];
    if (in_req_i.mouse_events[7:6] != 2'b00) begin
      for (int x = 0; x < 2; x++) begin
        if (in_req_i.x_select[x] && (mtmp[3+x] != xdown)) begin
          mtmp[3+x] = xdown;
          mchg      = 1'b1;
        end
      end
    end
  end

  // lowest held button
  always_comb begin
    bsel = '0;
    for (int b = hit_pkg::NUM_BTN - 1; b >= 0; b--) begin
      if (mouse_q[b]) bsel = 3'(b);
    end
    mnext = mouse_q & ~(hit_pkg::NUM_BTN'(1) << bsel);
  end

  always_comb begin
    state_d     = state_q;
    w_d         = w_q;
    n_d         = n_q;
    key_d       = key_q;
    last_d      = last_q;
    count_d     = count_q;
    mouse_d     = mouse_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    map_ctrl    = '{set: 1'b0, clr: 1'b0, key: in_req_i.key_code};
    ram_we      = 1'b0;
    ram_wdata   = {!in_req_i.by_scan, in_req_i.extended_key, in_req_i.scan_byte};
    ram_re      = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_d       = '0;
          out_d.kind  = hit_pkg::KIND_STATUS;
          out_d.last  = 1'b1;
          out_valid_d = 1'b1;
          unique case (in_req_i.op)
            hit_pkg::OP_KEY: begin
              if (in_req_i.key_code != '0) begin
                if (!in_req_i.key_up && !map_stat.key_held) begin
                  map_ctrl.set  = 1'b1;
                  ram_we        = 1'b1;
                  count_d       = count_q + 8'd1;
                  out_d.changed = 1'b1;
                end else if (in_req_i.key_up && map_stat.key_held) begin
                  map_ctrl.clr  = 1'b1;
                  count_d       = count_q - 8'd1;
                  out_d.changed = 1'b1;
                end
              end
            end
            hit_pkg::OP_MOUSE: begin
              mouse_d       = mtmp;
              out_d.changed = mchg;
            end
            hit_pkg::OP_RELEASE_ALL: begin
              if (!map_stat.any_held && (mouse_q == '0)) begin
                out_d.kind = hit_pkg::KIND_NOTHING;
              end else begin
                out_valid_d = 1'b0;
                w_d         = '0;
                n_d         = '0;
                state_d     = S_SCAN;
              end
            end
            default: ;
          endcase
          out_d.held_count = count_d;
          out_d.mouse_held = mouse_d;
        end
      end
      S_SCAN: begin
        map_ctrl.key = scan_key;
        if (!map_stat.any_held) begin
          state_d = S_MOUSE;
        end else if (!map_stat.word_nz) begin
          w_d = w_q + 1'b1;
        end else if (slot_free) begin
          map_ctrl.clr = 1'b1;
          ram_re       = 1'b1;
          count_d      = count_q - 8'd1;
          n_d          = n_q + 1'b1;
          key_d        = scan_key;
          last_d       = at_limit || (!map_stat.others_held && (mouse_q == '0));
          state_d      = S_EMIT;
        end
      end
      S_EMIT: begin
        out_d.kind             = hit_pkg::KIND_KEY_REL;
        out_d.code             = key_q;
        out_d.release_scan     = ram_rdata[7:0];
        out_d.release_extended = ram_rdata[8];
        out_d.virtual_mode     = ram_rdata[9];
        out_d.held_count       = count_q;
        out_d.mouse_held       = mouse_q;
        out_d.changed          = 1'b1;
        out_d.last             = last_q;
        out_valid_d            = 1'b1;
        state_d                = last_q ? S_IDLE : S_SCAN;
      end
      S_MOUSE: begin
        if (mouse_q == '0) begin
          state_d = S_IDLE;
        end else if (slot_free) begin
          mouse_d          = mnext;
          n_d              = n_q + 1'b1;
          out_d            = '0;
          out_d.kind       = hit_pkg::KIND_BTN_REL;
          out_d.code       = 8'(bsel);
          out_d.held_count = count_q;
          out_d.mouse_held = mnext;
          out_d.changed    = 1'b1;
          out_d.last       = at_limit || (mnext == '0);
          out_valid_d      = 1'b1;
          if (out_d.last) state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      w_q         <= '0;
      n_q         <= '0;
      key_q       <= '0;
      last_q      <= 1'b0;
      count_q     <= '0;
      mouse_q     <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      w_q         <= w_d;
      n_q         <= n_d;
      key_q       <= key_d;
      last_q      <= last_d;
      count_q     <= count_d;
      mouse_q     <= mouse_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
    end
  end

  hit_held_map u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (map_ctrl),
    .word_i (w_q),
    .stat_o (map_stat)
  );

  hit_meta_store u_meta (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (in_req_i.key_code),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (scan_key),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

endmodule

>>> hw/rtl/hit_meta_store.sv
// ----------------------------------------------------------------------------
// hit_meta_store
// Per-key metadata memory, one write and one registered read port.
// ----------------------------------------------------------------------------
module hit_meta_store (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [hit_pkg::KEY_W-1:0]   waddr_i,
  input  logic [hit_pkg::META_W-1:0]  wdata_i,
  input  logic                        re_i,
  input  logic [hit_pkg::KEY_W-1:0]   raddr_i,
  output logic [hit_pkg::META_W-1:0]  rdata_o
);

  logic [hit_pkg::META_W-1:0] mem_q [hit_pkg::NUM_KEYS];
  logic [hit_pkg::META_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/hit_held_map.sv
// ----------------------------------------------------------------------------
// hit_held_map
// Held-key bitmap with key lookup and lowest-set-bit search within a word.
// ----------------------------------------------------------------------------
module hit_held_map (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  hit_pkg::map_ctrl_t          ctrl_i,
  input  logic [hit_pkg::WIDX_W-1:0]  word_i,
  output hit_pkg::map_stat_t          stat_o
);

  logic [hit_pkg::NUM_WORDS-1:0][hit_pkg::WORD_BITS-1:0] bits_q, bits_d;
  logic [hit_pkg::NUM_KEYS-1:0]  flat;
  logic [hit_pkg::NUM_KEYS-1:0]  sel_mask;
  logic [hit_pkg::WORD_BITS-1:0] word;
  logic [hit_pkg::BIDX_W-1:0]    first;

  assign flat     = bits_q;
  assign sel_mask = {{(hit_pkg::NUM_KEYS-1){1'b0}}, 1'b1} << ctrl_i.key;
  assign word     = bits_q[word_i];

  always_comb begin
    first = '0;
    for (int i = hit_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (word[i]) first = hit_pkg::BIDX_W'(i);
    end
  end

  always_comb begin
    bits_d = bits_q;
    if (ctrl_i.set) begin
      bits_d = bits_q | sel_mask;
    end else if (ctrl_i.clr) begin
      bits_d = bits_q & ~sel_mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bits_q <= '0;
    end else begin
      bits_q <= bits_d;
    end
  end

  assign stat_o.key_held    = |(flat & sel_mask);
  assign stat_o.word_nz     = |word;
  assign stat_o.first_idx   = first;
  assign stat_o.any_held    = |flat;
  assign stat_o.others_held = |(flat & ~sel_mask);

endmodule

>>> hw/rtl/hit_checker.sv
// ----------------------------------------------------------------------------
// hit_checker
// Port-level checks for the held input tracker, bound to the top level.
// ----------------------------------------------------------------------------
module hit_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          in_valid_i,
  input logic          in_stall_o,
  input hit_pkg::req_t in_req_i,
  input logic          out_valid_o,
  input logic          out_stall_i,
  input hit_pkg::rsp_t out_rsp_o
);

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_req_i.op != hit_pkg::OP_RELEASE_ALL)
    |=> out_valid_o && out_rsp_o.last && (out_rsp_o.kind == hit_pkg::KIND_STATUS))
    else $error("event did not give a status result");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_rsp_o.kind == hit_pkg::KIND_NOTHING)
    |-> out_rsp_o.last && (out_rsp_o.held_count == '0) && (out_rsp_o.mouse_held == '0))
    else $error("nothing-held result with state held");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ((out_rsp_o.kind == hit_pkg::KIND_KEY_REL) ||
                    (out_rsp_o.kind == hit_pkg::KIND_BTN_REL))
    |-> out_rsp_o.changed)
    else $error("release without change");

endmodule

bind held_input_tracker_core hit_checker u_hit_checker (.*);
